FILE: rtl/core/hml_pkg.sv
// Shared codes and constants for the linear-probe hash map.
// Used by hml_mod_unit and hash_map_linear_probe; depends on nothing.
package hml_pkg;

    typedef logic [1:0] opcode_t;
    typedef logic [1:0] status_t;
    typedef logic [1:0] slot_state_t;

    localparam opcode_t OP_GET    = 2'd0;
    localparam opcode_t OP_PUT    = 2'd1;
    localparam opcode_t OP_REMOVE = 2'd2;

    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_NOT_FOUND = 2'd1;
    localparam status_t STATUS_FULL      = 2'd2;
    localparam status_t STATUS_BAD_KEY   = 2'd3;

    localparam slot_state_t SLOT_EMPTY = 2'd0;
    localparam slot_state_t SLOT_LIVE  = 2'd1;
    localparam slot_state_t SLOT_TOMB  = 2'd2;

    localparam int HASH_BITS        = 32;
    localparam int MOD_STEP         = 4;
    localparam int MIN_SIZE         = 3;
    localparam int SIZE_RESET_VALUE = 1021;

endpackage

FILE: rtl/core/hml_mod_unit.sv
// Iterative hash-modulo-size unit, MOD_STEP dividend bits per cycle.
// Depends on hml_pkg for HASH_BITS and MOD_STEP.
module hml_mod_unit
    import hml_pkg::*;
#(
    parameter int SIZE_BITS = 11
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [HASH_BITS-1:0] dividend,
    input  logic [SIZE_BITS-1:0] divisor,
    output logic                 done,
    output logic [SIZE_BITS-1:0] remainder
);

    localparam int ROUNDS   = HASH_BITS / MOD_STEP;
    localparam int CNT_BITS = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic [HASH_BITS-1:0] num_reg;
    logic [SIZE_BITS-1:0] rem_reg;

    logic [HASH_BITS-1:0] num_next;
    logic [SIZE_BITS-1:0] rem_next;
    logic [SIZE_BITS:0]   trial;

    // restoring remainder, MOD_STEP dividend bits per cycle
    always_comb
    begin
        num_next = num_reg;
        rem_next = rem_reg;
        trial    = '0;
        for (int i = 0; i < MOD_STEP; i++)
        begin
            trial    = {rem_next, num_next[HASH_BITS-1]};
            num_next = {num_next[HASH_BITS-2:0], 1'b0};
            if (trial >= {1'b0, divisor})
            begin
                trial = trial - {1'b0, divisor};
            end
            rem_next = trial[SIZE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(ROUNDS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

FILE: rtl/core/hml_slot_ram.sv
// Single-port-write, single-port-read slot memory with registered read data.
// No package dependency.
module hml_slot_ram
#(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 66,
    localparam int ADDR_BITS = $clog2(DEPTH)
)
(
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] slot_mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            slot_mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= slot_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/hash_map_linear_probe.sv
// Key-to-value table, open addressing with linear probing.
// Channels: in (in_valid/in_ready) takes opcode, key_id, key_hash, put_value;
// out (out_valid/out_ready) returns status, found, get_value, slot_index,
// entry_count, one word per request. cfg_we writes table_size from cfg_wdata
// at once; write it only while no request is in flight.
// A request with a nonzero key goes through these steps from acceptance to
// its result: the hash-modulo unit reduces key_hash by table_size, the first
// slot read is issued, each slot visited (at least one) is judged from one
// read of the slot memory, and the commit does the write-back and loads the
// result. A zero key skips the modulo and probe steps and goes to the commit.
// One request is worked at a time; the next is taken the cycle after the
// result is loaded.
// Reset clears the live count, sets table_size to 1021 (or the depth if
// smaller) and starts a clearing pass that marks all TABLE_DEPTH slots
// empty; in_ready stays low during it.
// When the receiver stalls, the finished word holds in the output register;
// the next request is still accepted and works up to its commit, then waits.
// Depends on hml_pkg, hml_mod_unit and hml_slot_ram.
module hash_map_linear_probe
    import hml_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_BITS    = 32,
    parameter int VALUE_BITS  = 32,
    localparam int IDX_BITS   = $clog2(TABLE_DEPTH),
    localparam int SIZE_BITS  = $clog2(TABLE_DEPTH + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [SIZE_BITS-1:0]  cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            opcode,
    input  logic [KEY_BITS-1:0]   key_id,
    input  logic [HASH_BITS-1:0]  key_hash,
    input  logic [VALUE_BITS-1:0] put_value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            status,
    output logic                  found,
    output logic [VALUE_BITS-1:0] get_value,
    output logic [IDX_BITS-1:0]   slot_index,
    output logic [SIZE_BITS-1:0]  entry_count
);

    localparam int ENTRY_BITS = 2 + KEY_BITS + VALUE_BITS;
    localparam logic [SIZE_BITS-1:0] SIZE_RESET =
        SIZE_BITS'((SIZE_RESET_VALUE > TABLE_DEPTH) ? TABLE_DEPTH : SIZE_RESET_VALUE);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_MOD    = 3'd2;
    localparam logic [2:0] S_PROBE  = 3'd3;
    localparam logic [2:0] S_COMMIT = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [IDX_BITS-1:0]   clr_reg, clr_next;
    logic [SIZE_BITS-1:0]  size_reg;
    logic [SIZE_BITS-1:0]  count_reg, count_next;
    logic                  put_reg, del_reg, bad_key_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [IDX_BITS-1:0]   cur_ix_reg, cur_ix_next;
    logic [SIZE_BITS-1:0]  n_reg, n_next;
    logic [IDX_BITS-1:0]   spare_ix_reg, spare_ix_next;
    logic                  spare_vld_reg, spare_vld_next;
    logic                  hit_reg, hit_next;
    logic [IDX_BITS-1:0]   pos_reg, pos_next;
    logic                  pos_vld_reg, pos_vld_next;
    logic [VALUE_BITS-1:0] got_reg, got_next;

    logic                  out_valid_reg;
    status_t               status_reg, status_next;
    logic                  found_reg, found_next;
    logic [VALUE_BITS-1:0] get_value_reg, get_value_next;
    logic [IDX_BITS-1:0]   slot_reg, slot_next;

    logic                  accept;
    logic                  mod_start;
    logic                  mod_done;
    logic [SIZE_BITS-1:0]  mod_rem;
    logic                  out_free;
    logic                  commit_fire;
    logic [SIZE_BITS-1:0]  size_m1;
    logic [SIZE_BITS-1:0]  size_clamped;

    logic                  mem_we;
    logic [IDX_BITS-1:0]   mem_waddr;
    logic [ENTRY_BITS-1:0] mem_wdata;
    logic                  mem_re;
    logic [IDX_BITS-1:0]   mem_raddr;
    logic [ENTRY_BITS-1:0] mem_rdata;

    slot_state_t           rd_state;
    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_value;
    logic                  rd_live, rd_tomb, rd_match;
    logic                  spare_vld_c;
    logic [IDX_BITS-1:0]   spare_c;
    logic                  last_probe;
    logic [IDX_BITS-1:0]   step_ix;
    logic                  insert_ok;

    hml_mod_unit #(
        .SIZE_BITS (SIZE_BITS)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (key_hash),
        .divisor   (size_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    hml_slot_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (ENTRY_BITS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign in_ready    = (state_reg == S_IDLE);
    assign accept      = in_valid && in_ready;
    assign mod_start   = accept && (key_id != '0);
    assign out_free    = !out_valid_reg || out_ready;
    assign commit_fire = (state_reg == S_COMMIT) && out_free;
    assign size_m1     = size_reg - SIZE_BITS'(1);

    always_comb
    begin
        if (cfg_wdata < SIZE_BITS'(MIN_SIZE))
        begin
            size_clamped = SIZE_BITS'(MIN_SIZE);
        end
        else if (cfg_wdata > SIZE_BITS'(TABLE_DEPTH))
        begin
            size_clamped = SIZE_BITS'(TABLE_DEPTH);
        end
        else
        begin
            size_clamped = cfg_wdata;
        end
    end

    // slot word layout: {state, key, value}
    assign rd_state = slot_state_t'(mem_rdata[ENTRY_BITS-1 -: 2]);
    assign rd_key   = mem_rdata[KEY_BITS+VALUE_BITS-1 -: KEY_BITS];
    assign rd_value = mem_rdata[VALUE_BITS-1:0];

    always_comb
    begin
        rd_live = 1'b0;
        rd_tomb = 1'b0;
        case (rd_state)
            SLOT_LIVE: rd_live = 1'b1;
            SLOT_TOMB: rd_tomb = 1'b1;
            default:   ;
        endcase
    end

    assign rd_match    = rd_live && (rd_key == key_reg);
    assign spare_vld_c = spare_vld_reg || rd_tomb;
    assign spare_c     = spare_vld_reg ? spare_ix_reg : cur_ix_reg;
    assign last_probe  = (n_reg == size_m1);
    assign step_ix     = (SIZE_BITS'(cur_ix_reg) == size_m1) ? '0
                                                             : cur_ix_reg + IDX_BITS'(1);
    assign insert_ok   = pos_vld_reg &&
                         ({1'b0, count_reg} + (SIZE_BITS+1)'(1) < {1'b0, size_reg});

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cur_ix_next    = cur_ix_reg;
        n_next         = n_reg;
        spare_ix_next  = spare_ix_reg;
        spare_vld_next = spare_vld_reg;
        hit_next       = hit_reg;
        pos_next       = pos_reg;
        pos_vld_next   = pos_vld_reg;
        got_next       = got_reg;
        count_next     = count_reg;
        status_next    = STATUS_OK;
        found_next     = 1'b0;
        get_value_next = '0;
        slot_next      = '0;
        mem_we         = 1'b0;
        mem_waddr      = pos_reg;
        mem_wdata      = {SLOT_LIVE, key_reg, val_reg};
        mem_re         = 1'b0;
        mem_raddr      = step_ix;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = {SLOT_EMPTY, {(KEY_BITS + VALUE_BITS){1'b0}}};
                clr_next  = clr_reg + IDX_BITS'(1);
                if (clr_reg == IDX_BITS'(TABLE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    hit_next     = 1'b0;
                    pos_vld_next = 1'b0;
                    state_next   = (key_id == '0) ? S_COMMIT : S_MOD;
                end
            end

            S_MOD:
            begin
                if (mod_done)
                begin
                    // issue the home-slot read
                    mem_re         = 1'b1;
                    mem_raddr      = mod_rem[IDX_BITS-1:0];
                    cur_ix_next    = mod_rem[IDX_BITS-1:0];
                    n_next         = '0;
                    spare_vld_next = 1'b0;
                    state_next     = S_PROBE;
                end
            end

            S_PROBE:
            begin
                if (rd_match)
                begin
                    hit_next   = 1'b1;
                    pos_next   = cur_ix_reg;
                    got_next   = rd_value;
                    state_next = S_COMMIT;
                end
                else if (!rd_live && !rd_tomb)
                begin
                    // empty slot ends the chain; prefer the first tombstone
                    pos_next     = spare_c;
                    pos_vld_next = 1'b1;
                    state_next   = S_COMMIT;
                end
                else if (last_probe)
                begin
                    pos_next     = spare_c;
                    pos_vld_next = spare_vld_c;
                    state_next   = S_COMMIT;
                end
                else
                begin
                    // read the next slot while this one is judged
                    mem_re         = 1'b1;
                    cur_ix_next    = step_ix;
                    n_next         = n_reg + SIZE_BITS'(1);
                    spare_ix_next  = spare_c;
                    spare_vld_next = spare_vld_c;
                end
            end

            S_COMMIT:
            begin
                if (bad_key_reg)
                begin
                    status_next = STATUS_BAD_KEY;
                end
                else if (put_reg)
                begin
                    if (hit_reg)
                    begin
                        mem_we     = commit_fire;
                        found_next = 1'b1;
                        slot_next  = pos_reg;
                    end
                    else if (insert_ok)
                    begin
                        mem_we     = commit_fire;
                        count_next = count_reg + SIZE_BITS'(1);
                        slot_next  = pos_reg;
                    end
                    else
                    begin
                        status_next = STATUS_FULL;
                    end
                end
                else if (del_reg)
                begin
                    if (hit_reg)
                    begin
                        mem_we     = commit_fire;
                        mem_wdata  = {SLOT_TOMB, key_reg, got_reg};
                        found_next = 1'b1;
                        slot_next  = pos_reg;
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - SIZE_BITS'(1);
                        end
                    end
                    else
                    begin
                        status_next = STATUS_NOT_FOUND;
                    end
                end
                else
                begin
                    if (hit_reg)
                    begin
                        found_next     = 1'b1;
                        get_value_next = got_reg;
                        slot_next      = pos_reg;
                    end
                    else
                    begin
                        status_next = STATUS_NOT_FOUND;
                    end
                end
                if (commit_fire)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            size_reg      <= SIZE_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            pos_vld_reg   <= 1'b0;
            spare_vld_reg <= 1'b0;
            n_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            hit_reg       <= hit_next;
            pos_vld_reg   <= pos_vld_next;
            spare_vld_reg <= spare_vld_next;
            n_reg         <= n_next;
            if (cfg_we)
            begin
                size_reg <= size_clamped;
            end
            if (commit_fire)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            put_reg     <= (opcode == OP_PUT) && (put_value != '0);
            del_reg     <= (opcode == OP_REMOVE) || ((opcode == OP_PUT) && (put_value == '0));
            bad_key_reg <= (key_id == '0);
            key_reg     <= key_id;
            val_reg     <= put_value;
        end
        cur_ix_reg   <= cur_ix_next;
        spare_ix_reg <= spare_ix_next;
        pos_reg      <= pos_next;
        got_reg      <= got_next;
        if (commit_fire)
        begin
            status_reg    <= status_next;
            found_reg     <= found_next;
            get_value_reg <= get_value_next;
            slot_reg      <= slot_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign found       = found_reg;
    assign get_value   = get_value_reg;
    assign slot_index  = slot_reg;
    assign entry_count = count_reg;

    // slot memory is written only by the clearing pass or a commit, never mid-probe
    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_CLEAR) || (state_reg == S_COMMIT))
        else $error("slot memory written outside clear or commit");

    a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE) |-> (n_reg < size_reg))
        else $error("probe ran past the table size");

    a_count_moves_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> ($past(state_reg) == S_COMMIT))
        else $error("live count changed outside a commit");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < SIZE_BITS'(TABLE_DEPTH))
        else $error("live count reached the table depth");

    a_mod_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> (state_reg == S_MOD))
        else $error("modulo result arrived outside the modulo phase");

endmodule
